[rtl/particle_motion_integrator_core_assert.svh]
// assertion macros used by the checker
`ifndef PARTICLE_MOTION_INTEGRATOR_CORE_ASSERT_SVH
`define PARTICLE_MOTION_INTEGRATOR_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the next cycle
`define PMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmi next-cycle check failed");

// antecedent and consequent in the same cycle
`define PMI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmi same-cycle check failed");

`endif

[rtl/pmi_pkg.sv]
// types, codes and microcode table of the particle motion integrator
package pmi_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned STEP_W     = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_FORCE_SCALE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POSITION_STEP = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VELOCITY_LIM  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENERGY_SCALE  = 2'd3;

  localparam logic [1:0] PHASE_NONE    = 2'd0;
  localparam logic [1:0] PHASE_INITIAL = 2'd1;
  localparam logic [1:0] PHASE_FINAL   = 2'd2;
  localparam logic [1:0] PHASE_UNUSED  = 2'd3;

  localparam logic [62:0] E63_MAX = {63{1'b1}};

  localparam logic [STEP_W-1:0] STEP_FIN = 4'd13;

  typedef enum logic [3:0] {
    A_ZERO, A_VX, A_VY, A_VZ, A_FX, A_FY, A_FZ, A_SQHI, A_SQLO
  } a_sel_e;

  typedef enum logic [1:0] {
    B_SAME, B_FS, B_PS, B_ES
  } b_sel_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_SQ_LOAD, WB_SQ_ADD, WB_VEL_X, WB_VEL_Y, WB_VEL_Z,
    WB_POS_X, WB_POS_Y, WB_POS_Z, WB_E_HI, WB_E_LO, WB_E_ADD
  } wb_e;

  typedef struct packed {
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    wb_e               wb;
    logic              jmp_no_energy;
    logic [STEP_W-1:0] tgt;
    logic              done;
  } ctl_t;

  // microcode: most words issue one product and write back the previous one
  function automatic ctl_t rom_word(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{a_sel: A_ZERO, b_sel: B_SAME, wb: WB_NONE, jmp_no_energy: 1'b0,
          tgt: '0, done: 1'b0};
    case (step)
      4'd0:  begin w.a_sel = A_VX;   w.b_sel = B_SAME; end
      4'd1:  begin w.a_sel = A_VY;   w.b_sel = B_SAME; w.wb = WB_SQ_LOAD; end
      4'd2:  begin w.a_sel = A_VZ;   w.b_sel = B_SAME; w.wb = WB_SQ_ADD; end
      4'd3:  begin w.a_sel = A_FX;   w.b_sel = B_FS;   w.wb = WB_SQ_ADD; end
      4'd4:  begin w.a_sel = A_FY;   w.b_sel = B_FS;   w.wb = WB_VEL_X; end
      4'd5:  begin w.a_sel = A_FZ;   w.b_sel = B_FS;   w.wb = WB_VEL_Y; end
      4'd6:  begin w.a_sel = A_VX;   w.b_sel = B_PS;   w.wb = WB_VEL_Z; end
      4'd7:  begin w.a_sel = A_VY;   w.b_sel = B_PS;   w.wb = WB_POS_X; end
      4'd8:  begin w.a_sel = A_VZ;   w.b_sel = B_PS;   w.wb = WB_POS_Y; end
      4'd9:  begin
        w.a_sel = A_SQHI; w.b_sel = B_ES; w.wb = WB_POS_Z;
        w.jmp_no_energy = 1'b1; w.tgt = STEP_FIN;
      end
      4'd10: begin w.a_sel = A_SQLO; w.b_sel = B_ES;   w.wb = WB_E_HI; end
      4'd11: begin w.wb = WB_E_LO; end
      4'd12: begin w.wb = WB_E_ADD; end
      STEP_FIN: begin w.done = 1'b1; end
      default: begin w.done = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

[rtl/particle_motion_integrator_core.sv]
// particle motion integrator: microcoded euler step with velocity clamp and energy totals
// energy steps run only for the initial or final phase; the result is registered
// one request at a time, the next taken once the result enters the free output register;
// the one shared 33x33 multiplier yields one product per microcode step
// reset (asynchronous, active low) clears the sequencer, the output valid,
// the coefficient registers and both energy totals
module particle_motion_integrator_core
  import pmi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z
  input  logic [287:0]          s_axis_tdata,
  // energy_phase
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // initial_energy, final_energy, two zero bits
  output logic [319:0]          m_axis_tdata
);

  logic [31:0] fs_q, ps_q, es_q;
  logic [30:0] lim_q;

  logic              busy_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q;
  logic [319:0]      out_data_q;

  logic [31:0] pos_q [3];
  logic [31:0] vel_q [3];
  logic [31:0] frc_q [3];
  logic [1:0]  phase_q;
  logic [63:0] sq_q, prod_q, ehi_q;
  logic [62:0] term_q, init_sum_q, final_sum_q;

  ctl_t        ctl;
  logic        accept, no_energy, fin_fire;
  logic [32:0] op_a, op_b;
  logic [65:0] prod_full;
  logic [1:0]  axis;
  logic [40:0] v_sum, lim_pos, lim_neg;
  logic [31:0] v_clamped, pos_new;
  logic [63:0] e_sum;
  logic [62:0] term_new;
  logic [63:0] add_sum;
  logic [62:0] sel_sum, sum_new;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign ctl       = rom_word(step_q);
  assign no_energy = (phase_q != PHASE_INITIAL) && (phase_q != PHASE_FINAL);
  assign fin_fire  = busy_q && ctl.done && (!out_valid_q || m_axis_tready);

  always_comb begin
    case (ctl.a_sel)
      A_VX:    op_a = {vel_q[0][31], vel_q[0]};
      A_VY:    op_a = {vel_q[1][31], vel_q[1]};
      A_VZ:    op_a = {vel_q[2][31], vel_q[2]};
      A_FX:    op_a = {frc_q[0][31], frc_q[0]};
      A_FY:    op_a = {frc_q[1][31], frc_q[1]};
      A_FZ:    op_a = {frc_q[2][31], frc_q[2]};
      A_SQHI:  op_a = {1'b0, sq_q[63:32]};
      A_SQLO:  op_a = {1'b0, sq_q[31:0]};
      default: op_a = '0;
    endcase
    case (ctl.b_sel)
      B_SAME:  op_b = op_a;
      B_FS:    op_b = {1'b0, fs_q};
      B_PS:    op_b = {1'b0, ps_q};
      B_ES:    op_b = {1'b0, es_q};
      default: op_b = '0;
    endcase
  end

  assign prod_full = $signed(op_a) * $signed(op_b);

  always_comb begin
    case (ctl.wb)
      WB_VEL_Y, WB_POS_Y: axis = 2'd1;
      WB_VEL_Z, WB_POS_Z: axis = 2'd2;
      default:            axis = 2'd0;
    endcase
  end

  // velocity gain and clamp, and position step
  always_comb begin
    v_sum   = {{9{vel_q[axis][31]}}, vel_q[axis]} + {prod_q[63], prod_q[63:24]};
    lim_pos = {10'd0, lim_q};
    lim_neg = -lim_pos;
    if ($signed(v_sum) > $signed(lim_pos)) begin
      v_clamped = lim_pos[31:0];
    end else if ($signed(v_sum) < $signed(lim_neg)) begin
      v_clamped = lim_neg[31:0];
    end else begin
      v_clamped = v_sum[31:0];
    end
    pos_new = pos_q[axis] + prod_q[55:24];
  end

  // energy term and saturating total
  always_comb begin
    e_sum = {1'b0, ehi_q[54:0], 8'd0} + {24'd0, prod_q[63:24]};
    if ((ehi_q[63:55] != 9'd0) || e_sum[63]) begin
      term_new = E63_MAX;
    end else begin
      term_new = e_sum[62:0];
    end
    sel_sum = (phase_q == PHASE_INITIAL) ? init_sum_q : final_sum_q;
    add_sum = {1'b0, sel_sum} + {1'b0, term_q};
    sum_new = add_sum[63] ? E63_MAX : add_sum[62:0];
  end

  always_comb begin
    step_d = step_q;
    if (accept) begin
      step_d = '0;
    end else if (busy_q && !ctl.done) begin
      if (ctl.jmp_no_energy && no_energy) begin
        step_d = ctl.tgt;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q        <= '0;
      ps_q        <= '0;
      lim_q       <= '0;
      es_q        <= '0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      init_sum_q  <= '0;
      final_sum_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_FORCE_SCALE:   fs_q  <= cfg_data_i;
          CFG_POSITION_STEP: ps_q  <= cfg_data_i;
          CFG_VELOCITY_LIM:  lim_q <= cfg_data_i[30:0];
          CFG_ENERGY_SCALE:  es_q  <= cfg_data_i;
          default: ;
        endcase
      end
      step_q <= step_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin_fire) begin
        busy_q <= 1'b0;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (busy_q && (ctl.wb == WB_E_ADD)) begin
        if (phase_q == PHASE_INITIAL) begin
          init_sum_q <= sum_new;
        end else begin
          final_sum_q <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
    if (accept) begin
      pos_q[0] <= s_axis_tdata[31:0];
      pos_q[1] <= s_axis_tdata[63:32];
      pos_q[2] <= s_axis_tdata[95:64];
      vel_q[0] <= s_axis_tdata[127:96];
      vel_q[1] <= s_axis_tdata[159:128];
      vel_q[2] <= s_axis_tdata[191:160];
      frc_q[0] <= s_axis_tdata[223:192];
      frc_q[1] <= s_axis_tdata[255:224];
      frc_q[2] <= s_axis_tdata[287:256];
      phase_q  <= s_axis_tuser;
    end else if (busy_q) begin
      case (ctl.wb)
        WB_SQ_LOAD:                   sq_q <= prod_q;
        WB_SQ_ADD:                    sq_q <= sq_q + prod_q;
        WB_VEL_X, WB_VEL_Y, WB_VEL_Z: vel_q[axis] <= v_clamped;
        WB_POS_X, WB_POS_Y, WB_POS_Z: pos_q[axis] <= pos_new;
        WB_E_HI:                      ehi_q <= prod_q;
        WB_E_LO:                      term_q <= term_new;
        default: ;
      endcase
    end
    if (fin_fire) begin
      out_data_q <= {2'b00, final_sum_q, init_sum_q, vel_q[2], vel_q[1], vel_q[0],
                     pos_q[2], pos_q[1], pos_q[0]};
    end
  end

endmodule

[rtl/pmi_checker.sv]
// port-level checker for the particle motion integrator, bound to the top level
`include "particle_motion_integrator_core_assert.svh"

module pmi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [319:0] m_axis_tdata
);

  // one request in flight at a time
  `PMI_ASSERT_NEXT(busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a result that newly appears comes with the sequencer freeing up
  `PMI_ASSERT_SAME(result_with_release, $rose(m_axis_tvalid), $rose(s_axis_tready))

  // a stalled result holds
  `PMI_ASSERT_NEXT(result_held, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind particle_motion_integrator_core pmi_checker u_pmi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/particle_motion_integrator_core_tb.sv]
// testbench for the particle motion integrator core: random and directed euler steps checked
module particle_motion_integrator_core_tb;
  import pmi_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]       phase;
    logic [2:0][31:0] frc;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] pos;
  } motion_t;

  typedef struct packed {
    logic [62:0]      e_final;
    logic [62:0]      e_init;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] pos;
  } motion_update_t;

  class motion_scoreboard;
    logic [31:0]    force_scale;
    logic [31:0]    position_step;
    logic [30:0]    velocity_limit;
    logic [31:0]    energy_scale;
    logic [62:0]    initial_sum;
    logic [62:0]    final_sum;
    motion_update_t predicted_q[$];
    int             errors;

    function new();
      force_scale    = '0;
      position_step  = '0;
      velocity_limit = '0;
      energy_scale   = '0;
      initial_sum    = '0;
      final_sum      = '0;
      errors         = 0;
    endfunction

    function void set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
      case (idx)
        CFG_FORCE_SCALE:   force_scale    = val;
        CFG_POSITION_STEP: position_step  = val;
        CFG_VELOCITY_LIM:  velocity_limit = val[30:0];
        CFG_ENERGY_SCALE:  energy_scale   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    // floor(v * k / 2^24)
    function longint scaled(input longint v, input logic [31:0] k);
      return (v * longint'({32'b0, k})) >>> 24;
    endfunction

    function logic [62:0] add_energy(input logic [62:0] total, input logic [63:0] sq);
      logic [95:0] prod;
      logic [62:0] term;
      logic [63:0] sum;
      prod = {32'b0, sq} * {64'b0, energy_scale};
      term = (prod[95:87] != '0) ? E63_MAX : prod[86:24];
      sum  = {1'b0, total} + {1'b0, term};
      return sum[63] ? E63_MAX : sum[62:0];
    endfunction

    function void note_request(input motion_t m);
      logic [63:0]    sq;
      logic [63:0]    mag;
      longint         v;
      longint         lim;
      longint         d;
      motion_update_t r;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        v   = $signed(m.vel[i]);
        mag = (v < 0) ? -v : v;
        sq += mag * mag;
      end
      if (m.phase == PHASE_INITIAL) initial_sum = add_energy(initial_sum, sq);
      else if (m.phase == PHASE_FINAL) final_sum = add_energy(final_sum, sq);
      lim = longint'({33'b0, velocity_limit});
      for (int i = 0; i < 3; i++) begin
        v = $signed(m.vel[i]) + scaled($signed(m.frc[i]), force_scale);
        if (v > lim) v = lim;
        else if (v < -lim) v = -lim;
        d = scaled(v, position_step);
        r.vel[i] = v[31:0];
        r.pos[i] = m.pos[i] + d[31:0];
      end
      r.e_init  = initial_sum;
      r.e_final = final_sum;
      predicted_q = {predicted_q, r};
    endfunction

    function void compare(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_update(input logic [319:0] d);
      motion_update_t want;
      motion_update_t got;
      string          axes;
      axes = "xyz";
      if (predicted_q.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      got  = d[317:0];
      for (int i = 0; i < 3; i++) begin
        compare($sformatf("new_pos_%c", axes[i]), {32'b0, want.pos[i]}, {32'b0, got.pos[i]});
        compare($sformatf("new_vel_%c", axes[i]), {32'b0, want.vel[i]}, {32'b0, got.vel[i]});
      end
      compare("initial_energy", {1'b0, want.e_init}, {1'b0, got.e_init});
      compare("final_energy", {1'b0, want.e_final}, {1'b0, got.e_final});
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [31:0]           cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [287:0]          s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [319:0]          m_axis_tdata;

  motion_scoreboard sb;
  int               stall_pct = 0;
  int               quiet     = 0;

  particle_motion_integrator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // handshakes sampled mid-cycle, they complete at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_addr_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(motion_t'({s_axis_tuser, s_axis_tdata}));
      if (m_axis_tvalid && m_axis_tready) sb.check_update(m_axis_tdata);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic motion_t motion(input int px, input int py, input int pz,
                                     input int vx, input int vy, input int vz,
                                     input int fx, input int fy, input int fz,
                                     input logic [1:0] ph);
    motion_t m;
    m.pos   = {pz, py, px};
    m.vel   = {vz, vy, vx};
    m.frc   = {fz, fy, fx};
    m.phase = ph;
    return m;
  endfunction

  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic motion_t random_motion();
    motion_t m;
    for (int i = 0; i < 3; i++) begin
      m.pos[i] = $urandom;
      m.vel[i] = random_q16();
      m.frc[i] = random_q16();
    end
    m.phase = 2'($urandom_range(0, 3));
    return m;
  endfunction

  task automatic send_motion(input motion_t m, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m[287:0];
    s_axis_tuser  <= m.phase;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] fs, input logic [31:0] ps,
                           input logic [31:0] vl, input logic [31:0] es);
    drain();
    write_reg(CFG_FORCE_SCALE, fs);
    write_reg(CFG_POSITION_STEP, ps);
    write_reg(CFG_VELOCITY_LIM, vl);
    write_reg(CFG_ENERGY_SCALE, es);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall);
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_motion(random_motion(), idle_pct);
  endtask

  initial begin
    sb = new();
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    configure(32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    send_motion(motion(0, 0, 0, 0, 0, 0, 0, 0, 0, PHASE_NONE), 0);
    send_motion(motion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, PHASE_INITIAL), 0);
    send_motion(motion(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, PHASE_FINAL), 0);
    send_motion(motion(32'h7FFF_FFFF, 0, 32'h8000_0000, 65536, -65536, 0,
                       1, -1, 0, PHASE_UNUSED), 0);
    send_motion(motion(32'h8000_0000, 32'h7FFF_FFFF, 0, -1, 1, 32'h7FFF_FFFF,
                       -1, 1, 0, PHASE_INITIAL), 0);
    send_motion(motion(32'h1234_5678, 32'hFEDC_BA98, 32'h5555_AAAA,
                       32'hAAAA_5555, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
                       32'h3333_CCCC, 32'hCCCC_3333, 32'h0000_FFFF, PHASE_FINAL), 0);

    // limit of one, bit 31 of the write data is dropped
    configure(32'h0080_0000, 32'hFFFF_FFFF, 32'h8001_0000, 32'h0000_0100);
    send_motion(motion(0, 0, 0, 32'h5_0000, -32'h5_0000, 65536, 0, 0, 0, PHASE_INITIAL), 0);
    send_motion(motion(0, 0, 0, -65536, 65536, 65537, 0, 0, 0, PHASE_FINAL), 0);
    send_motion(motion(0, 0, 0, -65537, 0, 65535, 0, 0, 0, PHASE_UNUSED), 0);
    send_motion(motion(0, 0, 0, 0, 0, 0, -1, 1, -3, PHASE_NONE), 0);
    send_motion(motion(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h3_0000, -32'h3_0000,
                       32'h7FFF_FFFF, -32'h4_0000, 32'h4_0000, 32'h8000_0000, PHASE_FINAL), 0);

    // zero limit
    configure(32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0000, 32'h0100_0000);
    send_motion(motion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, PHASE_NONE), 0);
    send_motion(motion(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, PHASE_UNUSED), 0);
    for (int i = 0; i < 4; i++) send_motion(random_motion(), 0);

    configure(32'h0100_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    run_random(300, 0, 0);

    configure($urandom, $urandom, $urandom, $urandom_range(0, 255));
    run_random(150, 78, 0);
    drain();
    run_random(150, 78, 0);

    configure(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    run_random(300, 0, 78);

    configure(32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom_range(0, 4095));
    run_random(300, 17, 17);

    // energy totals run into saturation from here on
    configure($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    run_random(300, 0, 0);

    configure($urandom, $urandom, $urandom, $urandom);
    run_random(150, 78, 78);
    run_random(150, 17, 17);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
